// ===== rtl/core/lpam_pkg.sv =====
// Shared types and constants of the logical-to-physical address map.
// Used by lpam_cfg_regs, lpam_xlate and logical_to_physical_address_map.
package lpam_pkg;

    // Default width of the byte count fields
    localparam int COUNT_BITS_DEF = 16;

    // Map word and register index widths
    localparam int MAP_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int PHYS_BITS  = 26;
    localparam int OFF_BITS   = 24;
    // Width of a window's remaining-byte figure (up to 128 KiB)
    localparam int REM_BITS   = 18;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INSN_MAP_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INSN_MAP_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_MAP      = 2'd2;

    // Segment codes in the top address byte
    localparam logic [7:0] SEG_LOG_DATA  = 8'h00;
    localparam logic [7:0] SEG_LOG_INSN  = 8'h01;
    localparam logic [7:0] SEG_PHYS_DATA = 8'h10;
    localparam logic [7:0] SEG_PHYS_INSN = 8'h11;
    localparam logic [7:0] SEG_PHYS_UNIF = 8'h12;

    // Target regions, also the top two bits of a physical address
    localparam logic [1:0] REGION_UNIFIED = 2'd0;
    localparam logic [1:0] REGION_INSN    = 2'd1;
    localparam logic [1:0] REGION_DATA    = 2'd2;

    // Map word bit that selects on-chip instruction memory
    localparam int MAP_INSN_BIT = 12;

    // Window sizes in bytes
    localparam logic [REM_BITS-1:0] DATA_LOW_SIZE = 18'h08000;
    localparam logic [REM_BITS-1:0] DATA_WIN_SIZE = 18'h04000;
    localparam logic [REM_BITS-1:0] INSN_WIN_SIZE = 18'h20000;

    // The three map words
    typedef struct packed {
        logic [MAP_BITS-1:0] insn_low;
        logic [MAP_BITS-1:0] insn_high;
        logic [MAP_BITS-1:0] data;
    } lpam_maps_t;

    // Status flags of one translated item
    typedef struct packed {
        logic       accepted;
        logic [1:0] region;
        logic       write_out;
    } lpam_status_t;

endpackage

// ===== rtl/core/lpam_cfg_regs.sv =====
// Map word registers of the address map, written through a plain write port.
// Depends on lpam_pkg.
module lpam_cfg_regs
    import lpam_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [MAP_BITS-1:0]     cfg_wdata,
    output lpam_maps_t              maps
);

    lpam_maps_t maps_reg;
    lpam_maps_t maps_next;

    // Decode the write onto one map word; other indexes are dropped
    always_comb begin
        maps_next = maps_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_INSN_MAP_LOW:  maps_next.insn_low  = cfg_wdata;
                CFG_INSN_MAP_HIGH: maps_next.insn_high = cfg_wdata;
                CFG_DATA_MAP:      maps_next.data      = cfg_wdata;
                default:           maps_next = maps_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maps_reg <= '0;
        end else begin
            maps_reg <= maps_next;
        end
    end

    assign maps = maps_reg;

endmodule

// ===== rtl/core/lpam_xlate.sv =====
// Combinational segment decode, address mapping and count clipping.
// Depends on lpam_pkg.
module lpam_xlate
    import lpam_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [31:0]           logical_address,
    input  logic [COUNT_BITS-1:0] byte_count,
    input  logic                  is_write,
    input  lpam_maps_t            maps,
    output logic [PHYS_BITS-1:0]  physical_address,
    output logic [COUNT_BITS-1:0] granted_count,
    output lpam_status_t          status
);

    // Compare width wide enough for both the count and a window size
    localparam int CMP_BITS = ((COUNT_BITS > REM_BITS) ? COUNT_BITS : REM_BITS) + 1;

    logic [7:0]            seg;
    logic [OFF_BITS-1:0]   off;
    logic [MAP_BITS-1:0]   insn_map;
    logic [PHYS_BITS-1:0]  phys;
    logic [1:0]            region;
    logic                  ok;
    logic                  clip_en;
    logic [REM_BITS-1:0]   remain;
    logic [CMP_BITS-1:0]   remain_ext;
    logic [CMP_BITS-1:0]   count_ext;
    logic [COUNT_BITS-1:0] count_clipped;

    assign seg = logical_address[31:24];
    assign off = logical_address[23:0];
    assign insn_map = off[17] ? maps.insn_high : maps.insn_low;

    // Decode the segment and build the target address
    always_comb begin
        phys    = '0;
        region  = REGION_UNIFIED;
        ok      = 1'b1;
        clip_en = 1'b0;
        remain  = '0;
        case (seg)
            SEG_LOG_DATA: begin
                if (off[23:15] == '0) begin
                    phys    = {REGION_DATA, off};
                    region  = REGION_DATA;
                    clip_en = 1'b1;
                    remain  = DATA_LOW_SIZE - {3'b000, off[14:0]};
                end else if (off[23:16] == '0 && off[15:14] == 2'b10) begin
                    clip_en = 1'b1;
                    remain  = DATA_WIN_SIZE - {4'b0000, off[13:0]};
                    if (maps.data[MAP_INSN_BIT]) begin
                        phys   = {REGION_INSN, 6'd0, maps.data[3:0], off[13:0]};
                        region = REGION_INSN;
                    end else begin
                        phys   = {REGION_UNIFIED, maps.data[9:0], off[13:0]};
                        region = REGION_UNIFIED;
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            SEG_LOG_INSN: begin
                if (off[23:18] == '0) begin
                    clip_en = 1'b1;
                    remain  = INSN_WIN_SIZE - {1'b0, off[16:0]};
                    if (insn_map[MAP_INSN_BIT]) begin
                        phys   = {REGION_INSN, off};
                        region = REGION_INSN;
                    end else begin
                        // Seven map bits above a 128 KiB offset always fit in 24 bits
                        phys   = {REGION_UNIFIED, insn_map[6:0], off[16:0]};
                        region = REGION_UNIFIED;
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            SEG_PHYS_DATA: begin
                phys   = {REGION_DATA, off};
                region = REGION_DATA;
            end
            SEG_PHYS_INSN: begin
                phys   = {REGION_INSN, off};
                region = REGION_INSN;
            end
            SEG_PHYS_UNIF: begin
                phys   = {REGION_UNIFIED, off};
                region = REGION_UNIFIED;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Clip the count at the window end: a request running past it gets the rest
    assign remain_ext = CMP_BITS'(remain);
    assign count_ext  = CMP_BITS'(byte_count);

    always_comb begin
        count_clipped = byte_count;
        if (clip_en && count_ext >= remain_ext) begin
            count_clipped = remain_ext[COUNT_BITS-1:0];
        end
    end

    // Zero everything but the write flag on a rejected item
    assign physical_address = ok ? phys : '0;
    assign granted_count    = ok ? count_clipped : '0;
    assign status.accepted  = ok;
    assign status.region    = ok ? region : REGION_UNIFIED;
    assign status.write_out = is_write;

endmodule

// ===== rtl/core/logical_to_physical_address_map.sv =====
// Top level of the logical-to-physical address map: input register,
// translate logic and result register. Depends on lpam_pkg, lpam_cfg_regs
// and lpam_xlate.
//
//  Channel  Direction  Handshake          Contents
//  s_       in         s_tvalid/s_tready  logical_address, byte_count, is_write
//  m_       out        m_tvalid/m_tready  physical_address, granted_count,
//                                         accepted, target_region, write_out
//  cfg_     in         cfg_wr_en          map word index and value
//
// One item per cycle unless m_tready stalls; each item passes the input
// register, then the result register around the decode logic.
// Reset (aresetn low at a clock edge) empties both stages and clears the
// map words to zero. A stall on m_tready holds the result register; the
// input register keeps accepting while the result stage can drain.
module logical_to_physical_address_map
    import lpam_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IN_BITS  = ((32 + COUNT_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_BITS = ((PHYS_BITS + COUNT_BITS + 4 + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // logical_address, byte_count, is_write (lowest bit up), zero filled
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_BITS-1:0]      s_tdata,
    // physical_address, granted_count, accepted, target_region, write_out
    // (lowest bit up), zero filled
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_BITS-1:0]     m_tdata,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [MAP_BITS-1:0]     cfg_wdata
);

    lpam_maps_t            maps;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [31:0]           in_addr_reg;
    logic [COUNT_BITS-1:0] in_count_reg;
    logic                  in_write_reg;

    logic [PHYS_BITS-1:0]  xl_phys;
    logic [COUNT_BITS-1:0] xl_count;
    lpam_status_t          xl_status;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PHYS_BITS-1:0]  out_phys_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    lpam_status_t          out_status_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  in_load;

    lpam_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .maps      (maps)
    );

    // Pipeline advance: result stage frees when empty or taken
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_addr_reg  <= s_tdata[31:0];
            in_count_reg <= s_tdata[32 +: COUNT_BITS];
            in_write_reg <= s_tdata[32 + COUNT_BITS];
        end
    end

    lpam_xlate #(
        .COUNT_BITS (COUNT_BITS)
    ) u_xlate (
        .logical_address  (in_addr_reg),
        .byte_count       (in_count_reg),
        .is_write         (in_write_reg),
        .maps             (maps),
        .physical_address (xl_phys),
        .granted_count    (xl_count),
        .status           (xl_status)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_phys_reg   <= xl_phys;
            out_count_reg  <= xl_count;
            out_status_reg <= xl_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({out_status_reg.write_out, out_status_reg.region,
                                 out_status_reg.accepted, out_count_reg, out_phys_reg});

    // A rejected result carries zero address, count and region
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_status_reg.accepted |->
            out_phys_reg == '0 && out_count_reg == '0
            && out_status_reg.region == REGION_UNIFIED)
        else $error("rejected item with nonzero payload");

    // The region matches the top bits of the physical address
    a_region_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_phys_reg[PHYS_BITS-1 -: 2] == out_status_reg.region)
        else $error("region does not match address");

    // Clipping never grows the count
    a_clip_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_count_reg <= $past(in_count_reg))
        else $error("granted count exceeds requested count");

    // An item in the input register is not dropped while the result stage is full
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_addr_reg))
        else $error("input item lost under stall");

endmodule
